### sv/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// types, codes and per-byte helper functions of the source tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_TAB    = 8'h09;

   typedef enum logic [4:0] {
      MODE_IDLE,
      MODE_EQ,
      MODE_PLUS,
      MODE_MINUS,
      MODE_DOT,
      MODE_DOT2,
      MODE_BANG,
      MODE_SLASH,
      MODE_LINE,
      MODE_BLOCK,
      MODE_BSTAR,
      MODE_IDENT,
      MODE_NUM,
      MODE_STR,
      MODE_SESC,
      MODE_CHR,
      MODE_CESC,
      MODE_CCLOSE
   } mode_type;

   typedef enum logic [2:0] {
      KIND_PUNCT,
      KIND_IDENT,
      KIND_NUM,
      KIND_STR,
      KIND_CHR,
      KIND_NL,
      KIND_INVALID,
      KIND_END
   } kind_type;

   typedef enum logic [4:0] {
      PUNCT_ASSIGN,
      PUNCT_EQ,
      PUNCT_ELLIPSIS,
      PUNCT_PERIOD,
      PUNCT_INCR,
      PUNCT_PLUS,
      PUNCT_ARROW,
      PUNCT_DECR,
      PUNCT_MINUS,
      PUNCT_LBRACKET,
      PUNCT_RBRACKET,
      PUNCT_LBRACE,
      PUNCT_RBRACE,
      PUNCT_LPAREN,
      PUNCT_RPAREN,
      PUNCT_SEMI,
      PUNCT_COLON,
      PUNCT_COMMA,
      PUNCT_HASH,
      PUNCT_STAR,
      PUNCT_AMP,
      PUNCT_NEQ,
      PUNCT_GT,
      PUNCT_LT
   } punct_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      kind_type   kind;
      punct_type  punct;
      logic [7:0] text_byte;
      logic       has_text;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                   count;
      rsp_type [MAX_RESULTS-1:0]    item;
   } step_type;

   typedef struct packed {
      mode_type mode;
      logic     tail_n;
      rsp_type  tail;
   } start_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } flush_type;

   function automatic rsp_type mk_punct(punct_type p);
      rsp_type r;
      r.kind      = KIND_PUNCT;
      r.punct     = p;
      r.text_byte = '0;
      r.has_text  = 1'b0;
      r.last      = 1'b1;
      return r;
   endfunction

   function automatic rsp_type mk_text(kind_type k, logic [7:0] c);
      rsp_type r;
      r.kind      = k;
      r.punct     = PUNCT_ASSIGN;
      r.text_byte = c;
      r.has_text  = 1'b1;
      r.last      = 1'b0;
      return r;
   endfunction

   function automatic rsp_type mk_term(kind_type k);
      rsp_type r;
      r.kind      = k;
      r.punct     = PUNCT_ASSIGN;
      r.text_byte = '0;
      r.has_text  = 1'b0;
      r.last      = 1'b1;
      return r;
   endfunction

   function automatic logic [7:0] decode_esc(logic [7:0] c);
      return (c == "n") ? 8'd10 : 8'd0;
   endfunction

   function automatic logic is_lower(logic [7:0] c);
      return (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   // lexing of a byte from the idle mode
   function automatic start_type start_fn(logic [7:0] c);
      start_type s;
      s.mode   = MODE_IDLE;
      s.tail_n = 1'b1;
      s.tail   = mk_term(KIND_INVALID);
      unique case (c)
         " ", CH_TAB: s.tail_n = 1'b0;
         CH_NL:       s.tail = mk_term(KIND_NL);
         "=":         begin s.mode = MODE_EQ;    s.tail_n = 1'b0; end
         "+":         begin s.mode = MODE_PLUS;  s.tail_n = 1'b0; end
         "-":         begin s.mode = MODE_MINUS; s.tail_n = 1'b0; end
         ".":         begin s.mode = MODE_DOT;   s.tail_n = 1'b0; end
         "!":         begin s.mode = MODE_BANG;  s.tail_n = 1'b0; end
         "/":         begin s.mode = MODE_SLASH; s.tail_n = 1'b0; end
         "\"":        begin s.mode = MODE_STR;   s.tail_n = 1'b0; end
         CH_QUOTE:    begin s.mode = MODE_CHR;   s.tail_n = 1'b0; end
         "[":         s.tail = mk_punct(PUNCT_LBRACKET);
         "]":         s.tail = mk_punct(PUNCT_RBRACKET);
         "{":         s.tail = mk_punct(PUNCT_LBRACE);
         "}":         s.tail = mk_punct(PUNCT_RBRACE);
         "(":         s.tail = mk_punct(PUNCT_LPAREN);
         ")":         s.tail = mk_punct(PUNCT_RPAREN);
         ";":         s.tail = mk_punct(PUNCT_SEMI);
         ":":         s.tail = mk_punct(PUNCT_COLON);
         ",":         s.tail = mk_punct(PUNCT_COMMA);
         "#":         s.tail = mk_punct(PUNCT_HASH);
         "*":         s.tail = mk_punct(PUNCT_STAR);
         "&":         s.tail = mk_punct(PUNCT_AMP);
         ">":         s.tail = mk_punct(PUNCT_GT);
         "<":         s.tail = mk_punct(PUNCT_LT);
         default: begin
            priority if (is_lower(c)) begin
               s.tail = mk_text(KIND_IDENT, c);
               s.mode = MODE_IDENT;
            end else if (is_digit(c)) begin
               s.tail = mk_text(KIND_NUM, c);
               s.mode = MODE_NUM;
            end else begin
               s.tail = mk_term(KIND_INVALID);
            end
         end
      endcase
      return s;
   endfunction

   // what a pending token still owes
   function automatic flush_type flush_fn(mode_type m, logic [7:0] held);
      flush_type f;
      f.count  = 2'd1;
      f.first  = mk_term(KIND_INVALID);
      f.second = mk_term(KIND_CHR);
      unique case (m)
         MODE_EQ:                 f.first = mk_punct(PUNCT_ASSIGN);
         MODE_PLUS:               f.first = mk_punct(PUNCT_PLUS);
         MODE_MINUS:              f.first = mk_punct(PUNCT_MINUS);
         MODE_DOT:                f.first = mk_punct(PUNCT_PERIOD);
         MODE_DOT2: begin
            f.count  = 2'd2;
            f.first  = mk_punct(PUNCT_PERIOD);
            f.second = mk_punct(PUNCT_PERIOD);
         end
         MODE_BANG, MODE_SLASH:   f.first = mk_term(KIND_INVALID);
         MODE_IDENT:              f.first = mk_term(KIND_IDENT);
         MODE_NUM:                f.first = mk_term(KIND_NUM);
         MODE_STR, MODE_SESC:     f.first = mk_term(KIND_STR);
         MODE_CHR, MODE_CESC: begin
            f.count = 2'd2;
            f.first = mk_text(KIND_CHR, 8'd0);
         end
         MODE_CCLOSE: begin
            f.count = 2'd2;
            f.first = mk_text(KIND_CHR, held);
         end
         default:                 f.count = 2'd0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

### sv/cst_lexer.sv
// ----------------------------------------------------------------------------
// cst_lexer
// lexer state and the per-byte step producing up to three tokens
// ----------------------------------------------------------------------------
`default_nettype none

module cst_lexer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire cst_pkg::req_type  req_data,
   output cst_pkg::step_type      step
);
   import cst_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] held_ff, held_in;

   start_type  st;
   flush_type  fl;
   logic       do_flush;
   logic       use_start;
   logic       tail_n;
   rsp_type    tail;
   logic [1:0] flush_n;
   logic [7:0] c;

   assign c  = req_data.ch;
   assign st = start_fn(c);
   assign fl = flush_fn(mode_ff, held_ff);

   always_comb begin
      do_flush  = 1'b0;
      use_start = 1'b0;
      tail_n    = 1'b0;
      tail      = mk_term(KIND_END);
      mode_in   = mode_ff;
      held_in   = held_ff;
      if (req_data.end_of_source) begin
         do_flush = 1'b1;
         tail_n   = 1'b1;
         tail     = mk_term(KIND_END);
      end else begin
         unique case (mode_ff)
            MODE_IDLE: use_start = 1'b1;
            MODE_EQ: begin
               if (c == "=") begin
                  tail_n = 1'b1; tail = mk_punct(PUNCT_EQ); mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_PLUS: begin
               if (c == "+") begin
                  tail_n = 1'b1; tail = mk_punct(PUNCT_INCR); mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_MINUS: begin
               priority if (c == ">") begin
                  tail_n = 1'b1; tail = mk_punct(PUNCT_ARROW); mode_in = MODE_IDLE;
               end else if (c == "-") begin
                  tail_n = 1'b1; tail = mk_punct(PUNCT_DECR); mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_DOT: begin
               if (c == ".") mode_in = MODE_DOT2;
               else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_DOT2: begin
               if (c == ".") begin
                  tail_n = 1'b1; tail = mk_punct(PUNCT_ELLIPSIS); mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_BANG: begin
               if (c == "=") begin
                  tail_n = 1'b1; tail = mk_punct(PUNCT_NEQ); mode_in = MODE_IDLE;
               end else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_SLASH: begin
               priority if (c == "*") mode_in = MODE_BLOCK;
               else if (c == "/") mode_in = MODE_LINE;
               else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_LINE: begin
               if (c == CH_NL) use_start = 1'b1;
            end
            MODE_BLOCK: begin
               if (c == "*") mode_in = MODE_BSTAR;
            end
            MODE_BSTAR: begin
               priority if (c == "/") mode_in = MODE_IDLE;
               else if (c != "*") mode_in = MODE_BLOCK;
               else mode_in = MODE_BSTAR;
            end
            MODE_IDENT: begin
               if (is_lower(c) || is_digit(c)) begin
                  tail_n = 1'b1; tail = mk_text(KIND_IDENT, c);
               end else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_NUM: begin
               if (is_digit(c)) begin
                  tail_n = 1'b1; tail = mk_text(KIND_NUM, c);
               end else begin
                  do_flush = 1'b1; use_start = 1'b1;
               end
            end
            MODE_STR: begin
               priority if (c == "\"") begin
                  tail_n = 1'b1; tail = mk_term(KIND_STR); mode_in = MODE_IDLE;
               end else if (c == CH_BSLASH) begin
                  mode_in = MODE_SESC;
               end else begin
                  tail_n = 1'b1; tail = mk_text(KIND_STR, c);
               end
            end
            MODE_SESC: begin
               tail_n  = 1'b1;
               tail    = mk_text(KIND_STR, decode_esc(c));
               mode_in = MODE_STR;
            end
            MODE_CHR: begin
               if (c == CH_BSLASH) mode_in = MODE_CESC;
               else begin
                  held_in = c; mode_in = MODE_CCLOSE;
               end
            end
            MODE_CESC: begin
               held_in = decode_esc(c);
               mode_in = MODE_CCLOSE;
            end
            MODE_CCLOSE: do_flush = 1'b1;
            default: begin
               do_flush = 1'b1; use_start = 1'b1;
            end
         endcase
      end
      if (do_flush) begin
         mode_in = MODE_IDLE;
         held_in = '0;
      end
      if (use_start) begin
         mode_in = st.mode;
         tail_n  = st.tail_n;
         tail    = st.tail;
      end
   end

   // flushed tokens first, then the token of the byte itself
   always_comb begin
      flush_n      = do_flush ? fl.count : 2'd0;
      step.count   = flush_n + {1'b0, tail_n};
      step.item[0] = (flush_n != 2'd0) ? fl.first : tail;
      step.item[1] = (flush_n == 2'd2) ? fl.second : tail;
      step.item[2] = tail;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         held_ff <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

### sv/c_like_source_tokenizer.sv
// ----------------------------------------------------------------------------
// c_like_source_tokenizer
// streaming tokenizer for a small c-like language, at most one source byte per cycle
// ----------------------------------------------------------------------------
// req channel: one source byte (or an end marker) per transaction.
// rsp channel: one token item per transaction; names, numbers, strings give
// one text item per char (an escape is one), char literals one; then a terminator.
// a byte is lexed in the cycle it is accepted; the up to three items it
// completes go into a four-entry result queue and, if the queue was empty,
// the first is offered on rsp the following cycle.
// req_ready is high while the queue holds at most one item, so a byte that
// yields zero or one item is taken every cycle while the receiver keeps up;
// a byte that yields two or three items holds off the next byte while the
// queue drains.  the queue drain rate (one item per cycle) sets the
// throughput.  reset empties the queue and returns the lexer to idle.  when
// the receiver stalls, the queue fills and req_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module c_like_source_tokenizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire cst_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output cst_pkg::rsp_type       rsp_data
);
   import cst_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   step_type         step;
   logic             accept;
   logic             pop;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] base;
   logic [CNT_W-1:0] push_n;
   rsp_type          q_ff [QUEUE_DEPTH];
   rsp_type          q_in [QUEUE_DEPTH];

   assign req_ready = cnt_ff <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && rsp_ready;

   cst_lexer u_lexer (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .step     (step)
   );

   assign base   = cnt_ff - CNT_W'(pop);
   assign push_n = accept ? CNT_W'(step.count) : '0;
   assign cnt_in = base + push_n;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_q
      logic [CNT_W-1:0] off;
      assign off = CNT_W'(i) - base;
      always_comb begin
         q_in[i] = q_ff[i];
         if (CNT_W'(i) < base) begin
            if (i + 1 < QUEUE_DEPTH && pop) q_in[i] = q_ff[(i + 1) % QUEUE_DEPTH];
         end else if (CNT_W'(i) < cnt_in) begin
            q_in[i] = step.item[off[1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.end_of_source |=> rsp_valid)
      else $error("end marker produced no result");

   a_text_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.has_text |-> !rsp_data.last)
      else $error("text item marked last");

endmodule

`default_nettype wire

### bench/tb_c_like_source_tokenizer.sv
// ----------------------------------------------------------------------------
// tb_c_like_source_tokenizer
// self-checking bench for the streaming source tokenizer
// ----------------------------------------------------------------------------
// source bytes and end markers are queued up front: a directed run over
// the corner cases, then random fragments of well-formed source (names,
// numbers, strings, char literals, operators, comments) mixed with noise
// bytes and end markers.  every accepted byte is run through a behavioural
// lexer in the bench, and each token item on rsp is checked field by field
// against the oldest predicted one.  idling on both sides changes in phases,
// and the receiver holds off once for a long stretch so the input stalls.
// ----------------------------------------------------------------------------

module tb_c_like_source_tokenizer;
   import cst_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   c_like_source_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   req_type   source_bytes[$];
   rsp_type   expected_tokens[$];
   int        stim_count = 0;
   int        bytes_offered = 0;
   int        send_idle_pct = 0;
   int        recv_stall_pct = 0;
   int        mismatch_count = 0;
   logic      hold_off = 1'b0;

   mode_type   lex_state = MODE_IDLE;
   logic [7:0] char_value = '0;

   string operator_text[$] = '{"=", "==", "+", "++", "-", "--", "->", ".", "..", "...",
                               "!", "!=", "/", "[", "]", "{", "}", "(", ")", ";", ":",
                               ",", "#", "*", "&", ">", "<"};

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- lexer

   function automatic logic ident_start(logic [7:0] c);
      return (c >= "a" && c <= "z") || c == "_";
   endfunction

   function automatic logic digit_char(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [7:0] escaped_value(logic [7:0] c);
      return (c == "n") ? 8'd10 : 8'd0;
   endfunction

   task automatic emit(kind_type k, punct_type p, logic [7:0] c, logic has, logic fin);
      rsp_type t;
      t.kind      = k;
      t.punct     = p;
      t.text_byte = c;
      t.has_text  = has;
      t.last      = fin;
      expected_tokens.push_back(t);
   endtask

   task automatic emit_punct(punct_type p);
      emit(KIND_PUNCT, p, 8'd0, 1'b0, 1'b1);
   endtask

   task automatic emit_text(kind_type k, logic [7:0] c);
      emit(k, PUNCT_ASSIGN, c, 1'b1, 1'b0);
   endtask

   task automatic emit_term(kind_type k);
      emit(k, PUNCT_ASSIGN, 8'd0, 1'b0, 1'b1);
   endtask

   // whatever the open token still owes
   task automatic owe_pending();
      case (lex_state)
         MODE_EQ:    emit_punct(PUNCT_ASSIGN);
         MODE_PLUS:  emit_punct(PUNCT_PLUS);
         MODE_MINUS: emit_punct(PUNCT_MINUS);
         MODE_DOT:   emit_punct(PUNCT_PERIOD);
         MODE_DOT2: begin
            emit_punct(PUNCT_PERIOD);
            emit_punct(PUNCT_PERIOD);
         end
         MODE_BANG, MODE_SLASH: emit_term(KIND_INVALID);
         MODE_IDENT: emit_term(KIND_IDENT);
         MODE_NUM:   emit_term(KIND_NUM);
         MODE_STR, MODE_SESC: emit_term(KIND_STR);
         MODE_CHR, MODE_CESC: begin
            emit_text(KIND_CHR, 8'd0);
            emit_term(KIND_CHR);
         end
         MODE_CCLOSE: begin
            emit_text(KIND_CHR, char_value);
            emit_term(KIND_CHR);
         end
         default: ;
      endcase
      lex_state  = MODE_IDLE;
      char_value = 8'd0;
   endtask

   task automatic lex_idle(logic [7:0] c);
      lex_state = MODE_IDLE;
      case (c)
         " ", CH_TAB: ;
         CH_NL:    emit_term(KIND_NL);
         "=":      lex_state = MODE_EQ;
         "+":      lex_state = MODE_PLUS;
         "-":      lex_state = MODE_MINUS;
         ".":      lex_state = MODE_DOT;
         "!":      lex_state = MODE_BANG;
         "/":      lex_state = MODE_SLASH;
         "\"":     lex_state = MODE_STR;
         CH_QUOTE: lex_state = MODE_CHR;
         "[":      emit_punct(PUNCT_LBRACKET);
         "]":      emit_punct(PUNCT_RBRACKET);
         "{":      emit_punct(PUNCT_LBRACE);
         "}":      emit_punct(PUNCT_RBRACE);
         "(":      emit_punct(PUNCT_LPAREN);
         ")":      emit_punct(PUNCT_RPAREN);
         ";":      emit_punct(PUNCT_SEMI);
         ":":      emit_punct(PUNCT_COLON);
         ",":      emit_punct(PUNCT_COMMA);
         "#":      emit_punct(PUNCT_HASH);
         "*":      emit_punct(PUNCT_STAR);
         "&":      emit_punct(PUNCT_AMP);
         ">":      emit_punct(PUNCT_GT);
         "<":      emit_punct(PUNCT_LT);
         default: begin
            if (ident_start(c)) begin
               emit_text(KIND_IDENT, c);
               lex_state = MODE_IDENT;
            end else if (digit_char(c)) begin
               emit_text(KIND_NUM, c);
               lex_state = MODE_NUM;
            end else begin
               emit_term(KIND_INVALID);
            end
         end
      endcase
   endtask

   task automatic restart(logic [7:0] c);
      owe_pending();
      lex_idle(c);
   endtask

   task automatic close_punct(punct_type p);
      emit_punct(p);
      lex_state = MODE_IDLE;
   endtask

   task automatic tokenize_byte(req_type r);
      logic [7:0] c;
      c = r.ch;
      if (r.end_of_source) begin
         owe_pending();
         emit_term(KIND_END);
      end else begin
         case (lex_state)
            MODE_IDLE:  lex_idle(c);
            MODE_EQ:    if (c == "=") close_punct(PUNCT_EQ); else restart(c);
            MODE_PLUS:  if (c == "+") close_punct(PUNCT_INCR); else restart(c);
            MODE_MINUS: begin
               if (c == ">") close_punct(PUNCT_ARROW);
               else if (c == "-") close_punct(PUNCT_DECR);
               else restart(c);
            end
            MODE_DOT:   if (c == ".") lex_state = MODE_DOT2; else restart(c);
            MODE_DOT2:  if (c == ".") close_punct(PUNCT_ELLIPSIS); else restart(c);
            MODE_BANG:  if (c == "=") close_punct(PUNCT_NEQ); else restart(c);
            MODE_SLASH: begin
               if (c == "*") lex_state = MODE_BLOCK;
               else if (c == "/") lex_state = MODE_LINE;
               else restart(c);
            end
            MODE_LINE:  if (c == CH_NL) lex_idle(c);
            MODE_BLOCK: if (c == "*") lex_state = MODE_BSTAR;
            MODE_BSTAR: begin
               if (c == "/") lex_state = MODE_IDLE;
               else if (c != "*") lex_state = MODE_BLOCK;
            end
            MODE_IDENT: begin
               if (ident_start(c) || digit_char(c)) emit_text(KIND_IDENT, c);
               else restart(c);
            end
            MODE_NUM:   if (digit_char(c)) emit_text(KIND_NUM, c); else restart(c);
            MODE_STR: begin
               if (c == "\"") begin
                  emit_term(KIND_STR);
                  lex_state = MODE_IDLE;
               end else if (c == CH_BSLASH) begin
                  lex_state = MODE_SESC;
               end else begin
                  emit_text(KIND_STR, c);
               end
            end
            MODE_SESC: begin
               emit_text(KIND_STR, escaped_value(c));
               lex_state = MODE_STR;
            end
            MODE_CHR: begin
               if (c == CH_BSLASH) begin
                  lex_state = MODE_CESC;
               end else begin
                  char_value = c;
                  lex_state  = MODE_CCLOSE;
               end
            end
            MODE_CESC: begin
               char_value = escaped_value(c);
               lex_state  = MODE_CCLOSE;
            end
            MODE_CCLOSE: owe_pending();
            default: begin
               lex_state  = MODE_IDLE;
               char_value = 8'd0;
               lex_idle(c);
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic add_byte(logic [7:0] c);
      req_type r;
      r.ch            = c;
      r.end_of_source = 1'b0;
      source_bytes.push_back(r);
      stim_count++;
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_end();
      req_type r;
      r.ch            = 8'($urandom_range(255));
      r.end_of_source = 1'b1;
      source_bytes.push_back(r);
      stim_count++;
   endtask

   task automatic add_fragment();
      int n;
      int r;
      n = $urandom_range(1, 5);
      case ($urandom_range(11))
         0, 1: begin
            add_byte(($urandom_range(5) == 0) ? 8'("_") : 8'($urandom_range("a", "z")));
            for (int i = 1; i < n; i++) begin
               r = $urandom_range(2);
               if (r == 0) add_byte(8'($urandom_range("a", "z")));
               else if (r == 1) add_byte(8'($urandom_range("0", "9")));
               else add_byte("_");
            end
         end
         2: for (int i = 0; i < n; i++) add_byte(8'($urandom_range("0", "9")));
         3: begin
            add_byte("\"");
            for (int i = 1; i < n; i++) begin
               if ($urandom_range(3) == 0) begin
                  add_byte(CH_BSLASH);
                  add_byte(($urandom_range(1) == 0) ? 8'("n") : 8'($urandom_range(255)));
               end else begin
                  add_byte(8'($urandom_range(255)));
               end
            end
            if ($urandom_range(9) != 0) add_byte("\"");
         end
         4: begin
            add_byte(CH_QUOTE);
            if ($urandom_range(2) == 0) begin
               add_byte(CH_BSLASH);
               r = $urandom_range(2);
               add_byte(r == 0 ? 8'("n") : r == 1 ? 8'("0") : 8'($urandom_range(255)));
            end else begin
               add_byte(8'($urandom_range(255)));
            end
            add_byte(($urandom_range(4) != 0) ? CH_QUOTE : 8'($urandom_range(255)));
         end
         5, 6: add_text(operator_text[$urandom_range(operator_text.size() - 1)]);
         7: begin
            if ($urandom_range(1) == 0) begin
               add_text("//");
               add_byte(8'($urandom_range(255)));
               add_byte(CH_NL);
            end else begin
               add_text("/*");
               add_byte(8'($urandom_range(255)));
               add_text("**/");
            end
         end
         8: begin
            r = $urandom_range(2);
            add_byte(r == 0 ? 8'(" ") : r == 1 ? CH_TAB : CH_NL);
         end
         9: add_byte(8'($urandom_range(255)));
         10: add_byte(8'($urandom_range("A", "Z")));
         default: add_end();
      endcase
   endtask

   initial begin
      // directed corner cases
      add_text("x9=...");
      add_text("!a");
      add_byte("\"");
      add_byte(CH_BSLASH);
      add_byte("n");
      add_byte(8'h00);
      add_byte(CH_NL);
      add_byte("\"");
      add_byte(CH_QUOTE);
      add_byte(CH_BSLASH);
      add_byte("q");
      add_byte(CH_QUOTE);
      add_byte(8'hff);
      add_text("/*/*/");
      add_byte(CH_QUOTE);
      add_byte("z");
      add_end();
      while (stim_count < 129) add_fragment();
      add_end();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (source_bytes.size() != 0 || req_valid || expected_tokens.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("c_like_source_tokenizer: match");
      else
         $display("c_like_source_tokenizer: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) tokenize_byte(req_data);
         if (!req_valid || req_ready) begin
            if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= source_bytes.pop_front();
               req_valid <= 1'b1;
               bytes_offered++;
               if (bytes_offered < 60) begin
                  send_idle_pct  = 0;
                  recv_stall_pct = 0;
               end else if (bytes_offered < 95) begin
                  send_idle_pct  = 84;
                  recv_stall_pct = 0;
               end else if (bytes_offered < 125) begin
                  send_idle_pct  = 0;
                  recv_stall_pct = 84;
               end else begin
                  send_idle_pct  = 22;
                  recv_stall_pct = 22;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (bytes_offered >= 20);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (60) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_tokens.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected transaction: kind %0d punct %0d text %h has %b last %b",
                           rsp_data.kind, rsp_data.punct, rsp_data.text_byte,
                           rsp_data.has_text, rsp_data.last);
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.punct !== want.punct ||
                   rsp_data.text_byte !== want.text_byte ||
                   rsp_data.has_text !== want.has_text || rsp_data.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("token differs: expected kind %0d punct %0d text %h has %b last %b",
                            want.kind, want.punct, want.text_byte, want.has_text,
                            want.last);
                     $display(", got kind %0d punct %0d text %h has %b last %b",
                              rsp_data.kind, rsp_data.punct, rsp_data.text_byte,
                              rsp_data.has_text, rsp_data.last);
                  end
               end
            end
         end
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #1000000;
      $display("c_like_source_tokenizer: mismatch");
      $finish;
   end

endmodule

### c_like_source_tokenizer.f
sv/cst_pkg.sv
sv/cst_lexer.sv
sv/c_like_source_tokenizer.sv
bench/tb_c_like_source_tokenizer.sv
